/* rtl/tsp_pkg.sv */
// Shared types and codes for the timer slot pool.
package tsp_pkg;

    // Command codes carried by an input request
    typedef enum logic [2:0] {
        CMD_ARM_PERIODIC = 3'd0,
        CMD_ARM_ONE_SHOT = 3'd1,
        CMD_TICK         = 3'd2,
        CMD_RESTART      = 3'd3,
        CMD_STOP         = 3'd4,
        CMD_SET_PERIOD   = 3'd5,
        CMD_READ_PERIOD  = 3'd6
    } cmd_t;

    // Sequencer states of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV
    } state_t;

    // Status of the divider unit
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Width of the period read-back field
    localparam int MS_OUT_W = 29;

    // Width of the handle slot field
    localparam int HSLOT_W = 3;

    // Status codes of a result
    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

endpackage

/* rtl/tsp_div.sv */
// Divider by a constant: reciprocal multiply, sixteen multiplier bits per cycle.
module tsp_div #(
    parameter int N       = 32,
    parameter int DIVISOR = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [N-1:0]          dividend,
    output tsp_pkg::div_stat_t    stat,
    output logic [N-1:0]          quotient
);

    // q = floor(n * M / 2^(N+L)) with M = floor(2^(N+L) / DIVISOR) + 1 is exact
    // for every N-bit n when L = ceil(log2(DIVISOR))
    localparam int L     = $clog2(DIVISOR);
    localparam int RCW   = N + L + 2;
    localparam int CHUNK = 16;
    localparam int NCH   = (N + 2 + CHUNK - 1) / CHUNK;
    localparam int MP_W  = NCH * CHUNK;
    localparam int ACC_W = N + MP_W;
    localparam int CW    = $clog2(NCH + 1);

    localparam logic [RCW-1:0]  POW     = RCW'(1) << (N + L);
    localparam logic [RCW-1:0]  RECIP   = (POW / RCW'(DIVISOR)) + RCW'(1);
    localparam logic [MP_W-1:0] RECIP_P = MP_W'(RECIP);

    logic [N-1:0]       num_reg;
    logic [MP_W-1:0]    recip_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [CHUNK-1:0]   chunk;
    logic [N+CHUNK-1:0] partial;
    logic [ACC_W-1:0]   acc_next;
    logic [ACC_W-1:0]   acc_shift;

    // Multiply by the next reciprocal chunk, most significant first, and fold in
    always_comb
    begin
        chunk     = recip_reg[MP_W-1 -: CHUNK];
        partial   = (N + CHUNK)'(num_reg) * (N + CHUNK)'(chunk);
        acc_next  = (acc_reg << CHUNK) + ACC_W'(partial);
        acc_shift = acc_reg >> (N + L);
    end

    // Hold the control state of the iteration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(NCH);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Advance the reciprocal chunks and the running product
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg   <= dividend;
            recip_reg <= RECIP_P;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            recip_reg <= recip_reg << CHUNK;
            acc_reg   <= acc_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = acc_shift[N-1:0];

endmodule

/* rtl/timer_slot_pool.sv */
// Timer slot pool: eight (NUM_TIMERS) count-down timers driven by commands.
//
// Input channel: in_valid / in_stall carry one command request (cmd, handle,
// period_value, period_in_ms). Output channel: out_valid / out_stall carry
// exactly one result request per command (status, handle after the command,
// expired flag, period read-back in milliseconds).
//
// Sequencing: a command is taken in the idle state and executed in the execute
// state; its result is loaded once the output register is free, and no new
// command is taken before that. Read period multiplies the stored period by a
// reciprocal of TICKS_IN_MS, sixteen multiplier bits per cycle, in the divide
// state. Counters and periods sit in one synchronous memory with a registered
// read; it is read as a command is taken and written as it executes.
//
// Reset: every slot is free and stopped with a zero period. Per-entry valid
// flops make memory entries read as zero until first written, so no clearing
// pass is needed and commands are taken right after reset.
//
// Stall: a finished result waits in the output register while out_stall is
// high; the next command is still taken and runs up to its own result.
module timer_slot_pool #(
    parameter int NUM_TIMERS  = 8,
    parameter int TICKS_IN_MS = 10,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [2:0]  handle_slot,
    input  logic        handle_allocated,
    input  logic [31:0] period_value,
    input  logic        period_in_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [2:0]  slot_out,
    output logic        allocated_out,
    output logic        expired,
    output logic [28:0] period_ms_out
);

    localparam int SW     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int TW     = $clog2(TICKS_IN_MS + 1);
    localparam int MUL_W  = 32 + TW;
    localparam int WIDE_W = (COUNT_WIDTH > MUL_W) ? COUNT_WIDTH : MUL_W;
    localparam int QW_W   = (COUNT_WIDTH > tsp_pkg::MS_OUT_W) ? COUNT_WIDTH
                                                              : tsp_pkg::MS_OUT_W;
    localparam int ROW_W  = 2 * COUNT_WIDTH;

    // Per-slot flags
    logic [NUM_TIMERS-1:0] slot_used_reg, slot_used_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;
    logic [NUM_TIMERS-1:0] single_reg, single_next;
    logic [NUM_TIMERS-1:0] ent_valid_reg, ent_valid_next;

    // Counter / period memory, row = {reload, count}
    logic [ROW_W-1:0] mem [NUM_TIMERS];
    logic [ROW_W-1:0] rd_data_reg;
    logic             mem_wr_en;
    logic [ROW_W-1:0] mem_wdata;

    tsp_pkg::state_t state_reg, state_next;

    // Command held for execution
    tsp_pkg::cmd_t          cmd_reg;
    logic [SW-1:0]          slot_reg;
    logic                   ign_reg;
    logic                   hit_reg;
    logic [COUNT_WIDTH-1:0] scaled_reg;
    logic [2:0]             res_slot_reg;
    logic                   res_alloc_reg;

    // Output register
    logic                           out_valid_reg, out_valid_next;
    logic                           status_reg;
    logic [2:0]                     slot_out_reg;
    logic                           alloc_out_reg;
    logic                           expired_reg;
    logic [tsp_pkg::MS_OUT_W-1:0]   ms_out_reg;
    logic                           out_load;
    logic                           ld_status;
    logic                           ld_expired;
    logic [tsp_pkg::MS_OUT_W-1:0]   ld_ms;

    // Accept-stage decode
    logic                   accept;
    logic                   out_free;
    tsp_pkg::cmd_t          cmd_in;
    logic [5:0]             hslot_w;
    logic [SW-1:0]          hslot_idx;
    logic                   valid_h;
    logic                   is_arm;
    logic                   pzero;
    logic                   free_found;
    logic [SW-1:0]          free_idx;
    logic [5:0]             free_w;
    logic                   claim;
    logic                   ign_in;
    logic [SW-1:0]          target;
    logic [2:0]             res_slot_in;
    logic                   res_alloc_in;
    logic [WIDE_W-1:0]      pval_wide;
    logic [WIDE_W-1:0]      prod_wide;
    logic [COUNT_WIDTH-1:0] scaled_in;

    // Execute-stage values
    logic [COUNT_WIDTH-1:0] row_reload;
    logic [COUNT_WIDTH-1:0] row_count;
    logic [COUNT_WIDTH-1:0] count_dec;
    logic [COUNT_WIDTH-1:0] div_quo;
    logic [QW_W-1:0]        quo_wide;
    logic                   div_start;
    tsp_pkg::div_stat_t     div_stat;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != tsp_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Decode the handle and look for the lowest free slot
    always_comb
    begin
        cmd_in     = tsp_pkg::cmd_t'(cmd);
        hslot_w    = 6'(handle_slot);
        hslot_idx  = hslot_w[SW-1:0];
        valid_h    = handle_allocated && (7'(handle_slot) < 7'(NUM_TIMERS));
        is_arm     = (cmd_in == tsp_pkg::CMD_ARM_PERIODIC) ||
                     (cmd_in == tsp_pkg::CMD_ARM_ONE_SHOT);
        pzero      = (period_value == 32'd0);
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!slot_used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
        free_w       = 6'(free_idx);
        claim        = 1'b0;
        target       = valid_h ? hslot_idx : '0;
        res_slot_in  = handle_slot;
        res_alloc_in = handle_allocated;
        if (is_arm)
        begin
            if (pzero)
            begin
                ign_in = 1'b1;
            end
            else if (valid_h)
            begin
                ign_in = 1'b0;
            end
            else if (free_found)
            begin
                ign_in       = 1'b0;
                claim        = 1'b1;
                target       = free_idx;
                res_slot_in  = free_w[2:0];
                res_alloc_in = 1'b1;
            end
            else
            begin
                ign_in = 1'b1;
            end
        end
        else
        begin
            unique case (cmd_in)
                tsp_pkg::CMD_TICK,
                tsp_pkg::CMD_RESTART,
                tsp_pkg::CMD_STOP,
                tsp_pkg::CMD_READ_PERIOD: ign_in = !valid_h;
                tsp_pkg::CMD_SET_PERIOD:  ign_in = !valid_h || pzero;
                default:                  ign_in = 1'b1;
            endcase
        end
    end

    // Scale a millisecond period into ticks, wrapped to the counter width
    always_comb
    begin
        pval_wide = WIDE_W'(period_value);
        prod_wide = pval_wide * WIDE_W'(TICKS_IN_MS);
        scaled_in = period_in_ms ? prod_wide[COUNT_WIDTH-1:0]
                                 : pval_wide[COUNT_WIDTH-1:0];
    end

    // Hold the accepted command for execution
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= cmd_in;
            slot_reg      <= target;
            ign_reg       <= ign_in;
            hit_reg       <= ent_valid_reg[target];
            scaled_reg    <= scaled_in;
            res_slot_reg  <= res_slot_in;
            res_alloc_reg <= res_alloc_in;
        end
    end

    // Read and write the counter memory
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= mem[target];
        end
        if (mem_wr_en)
        begin
            mem[slot_reg] <= mem_wdata;
        end
    end

    // Entries never written read as zero
    always_comb
    begin
        row_reload = hit_reg ? rd_data_reg[ROW_W-1:COUNT_WIDTH] : '0;
        row_count  = hit_reg ? rd_data_reg[COUNT_WIDTH-1:0] : '0;
        count_dec  = (row_count != '0) ? (row_count - COUNT_WIDTH'(1)) : '0;
        quo_wide   = QW_W'(div_quo);
    end

    // Sequence the command: execute, divide, hand over the result
    always_comb
    begin
        state_next     = state_reg;
        slot_used_next = slot_used_reg;
        running_next   = running_reg;
        single_next    = single_reg;
        ent_valid_next = ent_valid_reg;
        mem_wr_en      = 1'b0;
        mem_wdata      = {row_reload, row_count};
        div_start      = 1'b0;
        out_load       = 1'b0;
        ld_status      = tsp_pkg::STATUS_DONE;
        ld_expired     = 1'b0;
        ld_ms          = '0;
        unique case (state_reg)
            tsp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (claim)
                    begin
                        slot_used_next[target] = 1'b1;
                    end
                    state_next = tsp_pkg::ST_EXEC;
                end
            end
            tsp_pkg::ST_EXEC:
            begin
                if (ign_reg)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        ld_status  = tsp_pkg::STATUS_IGNORED;
                        state_next = tsp_pkg::ST_IDLE;
                    end
                end
                else if (cmd_reg == tsp_pkg::CMD_READ_PERIOD)
                begin
                    div_start  = 1'b1;
                    state_next = tsp_pkg::ST_DIV;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = tsp_pkg::ST_IDLE;
                    unique case (cmd_reg)
                        tsp_pkg::CMD_ARM_PERIODIC,
                        tsp_pkg::CMD_ARM_ONE_SHOT:
                        begin
                            mem_wr_en              = 1'b1;
                            mem_wdata              = {scaled_reg, scaled_reg};
                            ent_valid_next[slot_reg] = 1'b1;
                            running_next[slot_reg] = 1'b1;
                            single_next[slot_reg]  =
                                (cmd_reg == tsp_pkg::CMD_ARM_ONE_SHOT);
                        end
                        tsp_pkg::CMD_TICK:
                        begin
                            if (running_reg[slot_reg])
                            begin
                                mem_wr_en = 1'b1;
                                ent_valid_next[slot_reg] = 1'b1;
                                mem_wdata = {row_reload, count_dec};
                                if (count_dec == '0)
                                begin
                                    ld_expired = 1'b1;
                                    if (single_reg[slot_reg])
                                    begin
                                        running_next[slot_reg] = 1'b0;
                                    end
                                    else
                                    begin
                                        mem_wdata = {row_reload, row_reload};
                                    end
                                end
                            end
                        end
                        tsp_pkg::CMD_RESTART:
                        begin
                            mem_wr_en              = 1'b1;
                            mem_wdata              = {row_reload, row_reload};
                            ent_valid_next[slot_reg] = 1'b1;
                            running_next[slot_reg] = 1'b1;
                        end
                        tsp_pkg::CMD_STOP:
                        begin
                            running_next[slot_reg] = 1'b0;
                        end
                        tsp_pkg::CMD_SET_PERIOD:
                        begin
                            mem_wr_en              = 1'b1;
                            mem_wdata              = {scaled_reg, scaled_reg};
                            ent_valid_next[slot_reg] = 1'b1;
                        end
                        default:
                        begin
                            ld_status = tsp_pkg::STATUS_IGNORED;
                        end
                    endcase
                end
            end
            tsp_pkg::ST_DIV:
            begin
                if (div_stat.done && out_free)
                begin
                    out_load   = 1'b1;
                    ld_ms      = quo_wide[tsp_pkg::MS_OUT_W-1:0];
                    state_next = tsp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsp_pkg::ST_IDLE;
            end
        endcase
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Hold the control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsp_pkg::ST_IDLE;
            slot_used_reg <= '0;
            running_reg   <= '0;
            single_reg    <= '0;
            ent_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_used_reg <= slot_used_next;
            running_reg   <= running_next;
            single_reg    <= single_next;
            ent_valid_reg <= ent_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg    <= ld_status;
            slot_out_reg  <= res_slot_reg;
            alloc_out_reg <= res_alloc_reg;
            expired_reg   <= ld_expired;
            ms_out_reg    <= ld_ms;
        end
    end

    // Divide the stored period by the ticks per millisecond
    tsp_div #(
        .N       (COUNT_WIDTH),
        .DIVISOR (TICKS_IN_MS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (row_reload),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign slot_out      = slot_out_reg;
    assign allocated_out = alloc_out_reg;
    assign expired       = expired_reg;
    assign period_ms_out = ms_out_reg;

`ifndef SYNTHESIS
    // A taken command always moves on to execution
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == tsp_pkg::ST_EXEC))
        else $error("accepted command did not enter execution");

    // A result only appears out of execution or division
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) != tsp_pkg::ST_IDLE))
        else $error("result produced with no command in flight");

    // Slots are claimed and never given back
    a_slot_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (($past(slot_used_reg) & ~slot_used_reg) == '0))
        else $error("a claimed slot was freed");

    // While waiting on the divider it is either running or finished
    a_div_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tsp_pkg::ST_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");
`endif

endmodule

/* verif/timer_slot_pool_checker.sv */
// Request predictor and result checker for the timer slot pool.
`timescale 1ns / 100ps

module timer_slot_pool_checker
    import tsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [2:0]  handle_slot,
    input  logic        handle_allocated,
    input  logic [31:0] period_value,
    input  logic        period_in_ms,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        status,
    input  logic [2:0]  slot_out,
    input  logic        allocated_out,
    input  logic        expired,
    input  logic [28:0] period_ms_out,
    output int          error_count,
    output int          outstanding
);

    localparam int          NUM_SLOTS    = 8;
    localparam logic [31:0] TICK_SCALE   = 32'd10;
    localparam int          MAX_REPORTS  = 200;

    typedef struct packed {
        logic                status;
        logic [HSLOT_W-1:0]  slot;
        logic                allocated;
        logic                expired;
        logic [MS_OUT_W-1:0] ms_value;
    } pool_result_t;

    // Shadow copy of the timer pool
    logic        slot_claimed  [NUM_SLOTS];
    logic [31:0] ticks_left    [NUM_SLOTS];
    logic [31:0] reload_ticks  [NUM_SLOTS];
    logic        timer_running [NUM_SLOTS];
    logic        fires_once    [NUM_SLOTS];

    pool_result_t awaited_results[$];
    pool_result_t next_result;

    // Print one mismatch line and count it; keep the log bounded
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            if (error_count < MAX_REPORTS)
                $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
            error_count++;
        end
    endtask

    // Apply one command request to the shadow pool and work out its result
    task automatic predict_command(input logic [2:0] op, input logic [2:0] hs,
                                   input logic ha, input logic [31:0] pv,
                                   input logic ms, output pool_result_t r);
        logic [31:0] ticks;
        logic        found;
        int          s;
        begin
            r           = '0;
            r.status    = STATUS_DONE;
            r.slot      = hs;
            r.allocated = ha;
            s           = ha ? int'(hs) : 0;
            // scale milliseconds, wrapping to the counter width
            ticks       = ms ? pv * TICK_SCALE : pv;
            found       = ha;
            case (op)
                CMD_ARM_PERIODIC, CMD_ARM_ONE_SHOT:
                begin
                    if (pv == 32'd0)
                        r.status = STATUS_IGNORED;
                    else
                    begin
                        // claim the lowest free slot for a new handle
                        for (int i = 0; i < NUM_SLOTS && !found; i++)
                        begin
                            if (!slot_claimed[i])
                            begin
                                slot_claimed[i] = 1'b1;
                                s               = i;
                                r.slot          = HSLOT_W'(i);
                                r.allocated     = 1'b1;
                                found           = 1'b1;
                            end
                        end
                        if (!found)
                            r.status = STATUS_IGNORED;
                        else
                        begin
                            reload_ticks[s]  = ticks;
                            ticks_left[s]    = ticks;
                            fires_once[s]    = (op == CMD_ARM_ONE_SHOT);
                            timer_running[s] = 1'b1;
                        end
                    end
                end
                CMD_TICK, CMD_RESTART, CMD_STOP, CMD_SET_PERIOD, CMD_READ_PERIOD:
                begin
                    if (!ha)
                        r.status = STATUS_IGNORED;
                    else
                    begin
                        case (op)
                            CMD_TICK:
                            begin
                                // count down, then reload or stop on expiry
                                if (timer_running[s])
                                begin
                                    if (ticks_left[s] != 32'd0)
                                        ticks_left[s] = ticks_left[s] - 32'd1;
                                    if (ticks_left[s] == 32'd0)
                                    begin
                                        r.expired = 1'b1;
                                        if (fires_once[s])
                                            timer_running[s] = 1'b0;
                                        else
                                            ticks_left[s] = reload_ticks[s];
                                    end
                                end
                            end
                            CMD_RESTART:
                            begin
                                ticks_left[s]    = reload_ticks[s];
                                timer_running[s] = 1'b1;
                            end
                            CMD_STOP:
                                timer_running[s] = 1'b0;
                            CMD_SET_PERIOD:
                            begin
                                if (pv == 32'd0)
                                    r.status = STATUS_IGNORED;
                                else
                                begin
                                    reload_ticks[s] = ticks;
                                    ticks_left[s]   = ticks;
                                end
                            end
                            default:
                                r.ms_value = MS_OUT_W'(reload_ticks[s] / TICK_SCALE);
                        endcase
                    end
                end
                default:
                    r.status = STATUS_IGNORED;
            endcase
        end
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_result();
        pool_result_t want;
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result with nothing expected, slot", 32'(slot_out), 32'd0);
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (slot_out !== want.slot)
                    report_mismatch("slot_out", 32'(slot_out), 32'(want.slot));
                if (allocated_out !== want.allocated)
                    report_mismatch("allocated_out", 32'(allocated_out),
                                    32'(want.allocated));
                if (expired !== want.expired)
                    report_mismatch("expired", 32'(expired), 32'(want.expired));
                if (period_ms_out !== want.ms_value)
                    report_mismatch("period_ms_out", 32'(period_ms_out),
                                    32'(want.ms_value));
            end
        end
    endtask

    // Watch both channels: check results first, then predict new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_claimed[i]  = 1'b0;
                ticks_left[i]    = 32'd0;
                reload_ticks[i]  = 32'd0;
                timer_running[i] = 1'b0;
                fires_once[i]    = 1'b0;
            end
            awaited_results.delete();
            error_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
            begin
                predict_command(cmd, handle_slot, handle_allocated, period_value,
                                period_in_ms, next_result);
                awaited_results.push_back(next_result);
            end
            outstanding <= awaited_results.size();
        end
    end

endmodule

/* verif/timer_slot_pool_tb.sv */
// Testbench top for the timer slot pool: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module timer_slot_pool_tb;
    import tsp_pkg::*;

    localparam logic [2:0] CMD_UNUSED  = 3'd7;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         PHASE_ITEMS = 600;
    localparam int         RANDOM_ITEMS = 1750;

    logic        clk;
    logic        rst_n            = 1'b0;
    logic        in_valid         = 1'b0;
    logic        in_stall;
    logic [2:0]  cmd              = 3'd0;
    logic [2:0]  handle_slot      = 3'd0;
    logic        handle_allocated = 1'b0;
    logic [31:0] period_value     = 32'd0;
    logic        period_in_ms     = 1'b0;
    logic        out_valid;
    logic        out_stall        = 1'b0;
    logic        status;
    logic [2:0]  slot_out;
    logic        allocated_out;
    logic        expired;
    logic [28:0] period_ms_out;

    int error_count;
    int outstanding;
    int gap_pct   = 9;
    int stall_pct = 65;

    timer_slot_pool DUT (.*);

    timer_slot_pool_checker u_checker (.*);

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Stall the result channel at random
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Drive one command request and hold it until taken
    task automatic send_request(input logic [2:0] op, input logic [2:0] hs,
                                input logic ha, input logic [31:0] pv, input logic ms);
        begin
            while ($urandom_range(0, 99) < gap_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid         <= 1'b1;
            cmd              <= op;
            handle_slot      <= hs;
            handle_allocated <= ha;
            period_value     <= pv;
            period_in_ms     <= ms;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain_results();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (outstanding != 0)
                @(posedge clk);
        end
    endtask

    // End the run when neither channel moves for too long
    initial
    begin : hang_guard
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int          pick;
        int          kind;
        logic [2:0]  op;
        logic [31:0] pv;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Invalid handles and a zero period are ignored
        send_request(CMD_READ_PERIOD, 3'd0, 1'b0, 32'd0, 1'b0);
        send_request(CMD_TICK, 3'd5, 1'b0, 32'd0, 1'b0);
        send_request(CMD_ARM_PERIODIC, 3'd0, 1'b0, 32'd0, 1'b0);
        // Periodic timer in slot 0 expires on the third tick
        send_request(CMD_ARM_PERIODIC, 3'd0, 1'b0, 32'd3, 1'b0);
        repeat (3) send_request(CMD_TICK, 3'd0, 1'b1, 32'd0, 1'b0);
        // One-shot in ms takes slot 1, period reads back as 1 ms
        send_request(CMD_ARM_ONE_SHOT, 3'd0, 1'b0, 32'd1, 1'b1);
        send_request(CMD_READ_PERIOD, 3'd1, 1'b1, 32'd0, 1'b0);
        send_request(CMD_SET_PERIOD, 3'd1, 1'b1, 32'd0, 1'b0);
        // Scaled period wraps to zero: expires at once, then stays stopped
        send_request(CMD_SET_PERIOD, 3'd1, 1'b1, 32'h8000_0000, 1'b1);
        send_request(CMD_TICK, 3'd1, 1'b1, 32'd0, 1'b0);
        send_request(CMD_TICK, 3'd1, 1'b1, 32'd0, 1'b0);
        send_request(CMD_RESTART, 3'd1, 1'b1, 32'd0, 1'b0);
        send_request(CMD_STOP, 3'd1, 1'b1, 32'd0, 1'b0);
        // Allocated handle on an unmarked slot, largest period
        send_request(CMD_ARM_PERIODIC, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b0);
        send_request(CMD_READ_PERIOD, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_request(CMD_UNUSED, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1);
        // Claim the remaining slots, the last arm finds the pool full
        for (int k = 0; k < 7; k++)
            send_request(CMD_ARM_ONE_SHOT, 3'd0, 1'b0, $urandom_range(1, 5), 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Switch idling between phases; results are drained before the second phase
            if (n == PHASE_ITEMS)
            begin
                drain_results();
                gap_pct   = 65;
                stall_pct = 9;
            end
            else if (n == 2 * PHASE_ITEMS)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end

            // Weight ticks heavily so timers run down and expire
            pick = $urandom_range(0, 99);
            if (pick < 10)
                op = CMD_ARM_PERIODIC;
            else if (pick < 20)
                op = CMD_ARM_ONE_SHOT;
            else if (pick < 62)
                op = CMD_TICK;
            else if (pick < 70)
                op = CMD_RESTART;
            else if (pick < 75)
                op = CMD_STOP;
            else if (pick < 83)
                op = CMD_SET_PERIOD;
            else if (pick < 96)
                op = CMD_READ_PERIOD;
            else
                op = CMD_UNUSED;

            // Mostly short periods, with zero, wrapping and full-range values
            kind = $urandom_range(0, 9);
            if (kind == 0)
                pv = 32'd0;
            else if (kind == 1)
                pv = $urandom();
            else if (kind == 2)
                pv = 32'h8000_0000;
            else
                pv = $urandom_range(1, 6);

            send_request(op, 3'($urandom_range(0, 7)), ($urandom_range(0, 19) != 0), pv,
                         ($urandom_range(0, 3) == 0));
        end

        drain_results();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
